// ===== rtl/core/cdtq_pkg.sv =====
// shared types and constants for the deadline timer queue
package cdtq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int MAX_EXPIRE    = 16;
    localparam int ENTRY_W       = 32 + 32 + 32 + 32 + 16 + 32;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_GET    = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_CANCELLED = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EXPIRED   = 3'd4,
        ST_FULL      = 3'd5,
        ST_DUPLICATE = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_ACT,
        FSM_EMIT,
        FSM_WRITE
    } fsm_t;

    // one stored event
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] deadline;
        logic [31:0] order;
        logic [31:0] recv_mid;
        logic [15:0] handle;
        logic [31:0] resp_type;
    } entry_t;

endpackage

// ===== rtl/core/cdtq_ram.sv =====
// generic single port ram with registered read
module cdtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/core/cancellable_deadline_timer_queue_core.sv =====
// top level of the cancellable deadline timer queue
// Usage: one request per s_valid/s_ready handshake on the s_ channel; results
// leave on the m_ channel with m_last high on the final result of a request.
// Add, cancel and get give one result each; a tick gives zero to sixteen
// expired events, earliest deadline first, insertion order on ties.
// Entries live in one synchronous ram of TABLE_DEPTH words, read once a cycle.
// Every request scans the whole ram, then passes the action state and the
// output state; an add that stores an entry also passes a write state before
// the output state, and s_ready returns once the last result is in the output
// register. A tick repeats the scan once per expired event; a tick that finds
// nothing due gives no result and returns to idle after the action state.
// The block takes one request at a time; s_ready is low while it works.
// A stalled receiver holds the result in the output register; the next scan
// waits at its end until that register is free. Reset clears the valid bits,
// time and insertion count; ram contents are left as they are, and a word
// is used only while its valid bit is set.
module cancellable_deadline_timer_queue_core #(
    parameter int TABLE_DEPTH = cdtq_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [31:0] s_msg_id,
    input  logic [30:0] s_delay_ticks,
    input  logic [31:0] s_recv_mid,
    input  logic [15:0] s_recv_handle,
    input  logic [31:0] s_response_type,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_out_msg_id,
    output logic [31:0] m_out_recv_mid,
    output logic [15:0] m_out_recv_handle,
    output logic [31:0] m_out_response_type,
    output logic        m_last
);
    import cdtq_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = $clog2(MAX_EXPIRE + 1);

    fsm_t state_reg, state_next;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [31:0] now_reg, ins_reg;
    logic [1:0]  cmd_reg;
    logic [31:0] key_reg, dl_reg, rmid_reg, rtype_reg;
    logic [15:0] rhdl_reg;
    logic [CW-1:0] addr_reg;
    logic          rd_pend_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          hit_reg;
    logic [AW-1:0] hit_idx_reg;
    logic          best_reg;
    logic          more_reg;
    logic [AW-1:0] best_idx_reg;
    entry_t        best_ent_reg;
    logic [EW-1:0] nexp_reg;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    entry_t        ram_wdata, ram_rdata;

    logic          out_full_reg;
    logic [2:0]    o_status_reg;
    logic [31:0]   o_id_reg, o_mid_reg, o_rt_reg;
    logic [15:0]   o_hdl_reg;
    logic          o_last_reg;

    logic          s_fire, m_fire, scan_done, free_ok, rd_due, rd_first;
    logic [AW-1:0] free_idx;
    logic [31:0]   d_diff, pa, pb, oa, ob;

    cdtq_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign s_fire    = s_valid && s_ready;
    assign m_fire    = m_valid && m_ready;
    assign scan_done = (addr_reg == CW'(TABLE_DEPTH)) && !rd_pend_reg;

    // lowest free slot
    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_ok  = 1'b1;
                free_idx = AW'(i);
            end
        end
    end

    // due test and ordering of the entry just read against the best so far
    always_comb begin
        d_diff   = ram_rdata.deadline - now_reg;
        rd_due   = (d_diff == 32'd0) || d_diff[31];
        pa       = now_reg - ram_rdata.deadline;
        pb       = now_reg - best_ent_reg.deadline;
        oa       = ins_reg - ram_rdata.order;
        ob       = ins_reg - best_ent_reg.order;
        rd_first = (pa != pb) ? (pa > pb) : (oa > ob);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:  if (s_fire) state_next = FSM_SCAN;
            FSM_SCAN:  if (scan_done && !out_full_reg) state_next = FSM_ACT;
            FSM_ACT: begin
                if (cmd_reg == CMD_ADD && !hit_reg && free_ok) begin
                    state_next = FSM_WRITE;
                end else if (cmd_reg == CMD_TICK && !best_reg) begin
                    state_next = FSM_IDLE;
                end else begin
                    state_next = FSM_EMIT;
                end
            end
            FSM_WRITE: state_next = FSM_EMIT;
            FSM_EMIT: begin
                if (!out_full_reg || m_fire) begin
                    if (cmd_reg == CMD_TICK && !o_last_reg) begin
                        state_next = FSM_SCAN;
                    end else begin
                        state_next = FSM_IDLE;
                    end
                end
            end
            default:   state_next = FSM_IDLE;
        endcase
    end

    // ram port control
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = addr_reg[AW-1:0];
        ram_wdata = '{key: key_reg, deadline: dl_reg, order: ins_reg,
                      recv_mid: rmid_reg, handle: rhdl_reg, resp_type: rtype_reg};
        if (state_reg == FSM_WRITE) begin
            ram_we   = 1'b1;
            ram_addr = free_idx;
        end else if (state_reg == FSM_ACT) begin
            ram_addr = hit_idx_reg;
        end
    end

    assign s_ready             = (state_reg == FSM_IDLE);
    assign m_valid             = out_full_reg;
    assign m_status            = o_status_reg;
    assign m_out_msg_id        = o_id_reg;
    assign m_out_recv_mid      = o_mid_reg;
    assign m_out_recv_handle   = o_hdl_reg;
    assign m_out_response_type = o_rt_reg;
    assign m_last              = o_last_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            valid_reg    <= '0;
            now_reg      <= '0;
            ins_reg      <= '0;
            out_full_reg <= 1'b0;
            rd_pend_reg  <= 1'b0;
            addr_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (m_fire) out_full_reg <= 1'b0;
            case (state_reg)
                FSM_IDLE: begin
                    if (s_fire) begin
                        addr_reg    <= '0;
                        rd_pend_reg <= 1'b0;
                        if (s_cmd == CMD_TICK) now_reg <= now_reg + 32'd1;
                    end
                end
                FSM_SCAN: begin
                    rd_pend_reg <= (addr_reg != CW'(TABLE_DEPTH));
                    if (addr_reg != CW'(TABLE_DEPTH)) addr_reg <= addr_reg + CW'(1);
                end
                FSM_ACT: begin
                    if (cmd_reg == CMD_CANCEL || cmd_reg == CMD_GET) begin
                        if (hit_reg) valid_reg[hit_idx_reg] <= 1'b0;
                    end
                    if (cmd_reg == CMD_TICK && best_reg) valid_reg[best_idx_reg] <= 1'b0;
                end
                FSM_WRITE: begin
                    valid_reg[free_idx] <= 1'b1;
                    ins_reg             <= ins_reg + 32'd1;
                end
                FSM_EMIT: begin
                    if (!out_full_reg || m_fire) begin
                        out_full_reg <= 1'b1;
                        addr_reg     <= '0;
                        rd_pend_reg  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // request, scan and result payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg   <= s_cmd;
            key_reg   <= s_msg_id;
            dl_reg    <= now_reg + {1'b0, s_delay_ticks};
            rmid_reg  <= s_recv_mid;
            rhdl_reg  <= s_recv_handle;
            rtype_reg <= s_response_type;
            nexp_reg  <= '0;
        end
        if (state_reg == FSM_SCAN) begin
            rd_idx_reg <= addr_reg[AW-1:0];
            if (addr_reg == '0) begin
                hit_reg  <= 1'b0;
                best_reg <= 1'b0;
                more_reg <= 1'b0;
            end
            if (rd_pend_reg && valid_reg[rd_idx_reg]) begin
                if (ram_rdata.key == key_reg && !hit_reg) begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= rd_idx_reg;
                end
                // a second due entry means this expiry is not the last
                if (rd_due && best_reg) more_reg <= 1'b1;
                if (rd_due && (!best_reg || rd_first)) begin
                    best_reg     <= 1'b1;
                    best_idx_reg <= rd_idx_reg;
                    best_ent_reg <= ram_rdata;
                end
            end
        end
        if (state_reg == FSM_ACT) begin
            if (cmd_reg == CMD_TICK) begin
                o_status_reg <= ST_EXPIRED;
                o_id_reg     <= best_ent_reg.key;
                o_mid_reg    <= best_ent_reg.recv_mid;
                o_hdl_reg    <= best_ent_reg.handle;
                o_rt_reg     <= best_ent_reg.resp_type;
                nexp_reg     <= nexp_reg + EW'(1);
                o_last_reg   <= !more_reg || (nexp_reg == EW'(MAX_EXPIRE - 1));
            end else begin
                o_id_reg   <= key_reg;
                o_mid_reg  <= '0;
                o_hdl_reg  <= '0;
                o_rt_reg   <= '0;
                o_last_reg <= 1'b1;
                case (cmd_reg)
                    CMD_ADD: begin
                        if (hit_reg)       o_status_reg <= ST_DUPLICATE;
                        else if (!free_ok) o_status_reg <= ST_FULL;
                        else               o_status_reg <= ST_ADDED;
                    end
                    CMD_CANCEL: o_status_reg <= ST_CANCELLED;
                    CMD_GET:    o_status_reg <= hit_reg ? ST_FOUND : ST_NOT_FOUND;
                    default:    o_status_reg <= ST_CANCELLED;
                endcase
            end
        end
        // get payload arrives from the ram in the cycle after the action read
        if (state_reg == FSM_EMIT && cmd_reg == CMD_GET && hit_reg && !out_full_reg) begin
            o_mid_reg <= ram_rdata.recv_mid;
            o_hdl_reg <= ram_rdata.handle;
            o_rt_reg  <= ram_rdata.resp_type;
        end
    end

    // assertions
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !rd_pend_reg || state_reg == FSM_IDLE) else $error("ready outside idle");
    a_write_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !valid_reg[free_idx]) else $error("write over live entry");
    a_ins_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_reg != $past(ins_reg) |-> $past(state_reg) == FSM_WRITE)
        else $error("insertion count moved outside write");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_msg_id)
        && $stable(m_last)) else $error("result changed while stalled");
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_EXPIRED |-> m_last)
        else $error("single result without last");
endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the cancellable deadline timer queue core
module testbench;
    import cdtq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int N_RANDOM  = 450;
    localparam int IDLE_LIM  = 20000;
    localparam int TAIL_WAIT = 200;

    // one result as seen on the m_ channel
    typedef struct packed {
        status_t     status;
        logic [31:0] msg_id;
        logic [31:0] recv_mid;
        logic [15:0] handle;
        logic [31:0] resp_type;
        logic        last;
    } timer_result_t;

    // one request on the s_ channel
    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] msg_id;
        logic [30:0] delay;
        logic [31:0] recv_mid;
        logic [15:0] handle;
        logic [31:0] resp_type;
    } timer_req_t;

    // directed row: request plus optional hand-typed expectation
    typedef struct {
        timer_req_t    req;
        bit            typed;
        timer_result_t res;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic [31:0] s_msg_id;
    logic [30:0] s_delay_ticks;
    logic [31:0] s_recv_mid;
    logic [15:0] s_recv_handle;
    logic [31:0] s_response_type;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_out_msg_id;
    logic [31:0] m_out_recv_mid;
    logic [15:0] m_out_recv_handle;
    logic [31:0] m_out_response_type;
    logic        m_last;

    cancellable_deadline_timer_queue_core #(.TABLE_DEPTH(DEPTH)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_msg_id(s_msg_id), .s_delay_ticks(s_delay_ticks),
        .s_recv_mid(s_recv_mid), .s_recv_handle(s_recv_handle),
        .s_response_type(s_response_type),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_out_msg_id(m_out_msg_id), .m_out_recv_mid(m_out_recv_mid),
        .m_out_recv_handle(m_out_recv_handle),
        .m_out_response_type(m_out_response_type), .m_last(m_last)
    );

    // predictor state
    logic [31:0] pr_now;
    logic [31:0] pr_seq;
    bit          pr_valid [DEPTH];
    logic [31:0] pr_key [DEPTH];
    logic [31:0] pr_due [DEPTH];
    logic [31:0] pr_order [DEPTH];
    logic [31:0] pr_mid [DEPTH];
    logic [15:0] pr_handle [DEPTH];
    logic [31:0] pr_resp [DEPTH];

    timer_result_t pending_results [$];
    int  errors;
    int  idle_cycles;
    bit  calm;
    logic [31:0] used_keys [$];

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int find_slot(logic [31:0] key);
        for (int i = 0; i < DEPTH; i++)
            if (pr_valid[i] && pr_key[i] == key) return i;
        return -1;
    endfunction

    function automatic timer_result_t make_result(status_t st, logic [31:0] key, int idx);
        timer_result_t r;
        r = '0;
        r.status = st;
        r.msg_id = key;
        r.last   = 1'b1;
        if (idx >= 0) begin
            r.recv_mid  = pr_mid[idx];
            r.handle    = pr_handle[idx];
            r.resp_type = pr_resp[idx];
        end
        return r;
    endfunction

    // predict the results of one request and queue them
    task automatic predict_request(timer_req_t q);
        int idx;
        int best;
        int n;
        logic [31:0] d;
        logic [31:0] pa;
        logic [31:0] pb;
        case (q.cmd)
            CMD_ADD: begin
                idx = -1;
                if (find_slot(q.msg_id) >= 0) begin
                    pending_results.push_back(make_result(ST_DUPLICATE, q.msg_id, -1));
                end else begin
                    for (int i = DEPTH - 1; i >= 0; i--)
                        if (!pr_valid[i]) idx = i;
                    if (idx < 0) begin
                        pending_results.push_back(make_result(ST_FULL, q.msg_id, -1));
                    end else begin
                        pr_valid[idx]  = 1'b1;
                        pr_key[idx]    = q.msg_id;
                        pr_due[idx]    = pr_now + {1'b0, q.delay};
                        pr_order[idx]  = pr_seq;
                        pr_seq         = pr_seq + 1;
                        pr_mid[idx]    = q.recv_mid;
                        pr_handle[idx] = q.handle;
                        pr_resp[idx]   = q.resp_type;
                        pending_results.push_back(make_result(ST_ADDED, q.msg_id, -1));
                    end
                end
            end
            CMD_CANCEL: begin
                idx = find_slot(q.msg_id);
                if (idx >= 0) pr_valid[idx] = 1'b0;
                pending_results.push_back(make_result(ST_CANCELLED, q.msg_id, -1));
            end
            CMD_GET: begin
                idx = find_slot(q.msg_id);
                if (idx < 0) begin
                    pending_results.push_back(make_result(ST_NOT_FOUND, q.msg_id, -1));
                end else begin
                    pending_results.push_back(make_result(ST_FOUND, q.msg_id, idx));
                    pr_valid[idx] = 1'b0;
                end
            end
            default: begin
                pr_now = pr_now + 1;
                n = 0;
                while (n < MAX_EXPIRE) begin
                    best = -1;
                    for (int i = 0; i < DEPTH; i++) begin
                        d = pr_due[i] - pr_now;
                        if (!pr_valid[i] || !(d == 0 || d[31])) continue;
                        if (best < 0) begin
                            best = i;
                        end else begin
                            pa = pr_now - pr_due[i];
                            pb = pr_now - pr_due[best];
                            if (pa != pb) begin
                                if (pa > pb) best = i;
                            end else if ((pr_seq - pr_order[i]) > (pr_seq - pr_order[best])) begin
                                best = i;
                            end
                        end
                    end
                    if (best < 0) break;
                    pending_results.push_back(make_result(ST_EXPIRED, pr_key[best], best));
                    pending_results[$].last = 1'b0;
                    pr_valid[best] = 1'b0;
                    n++;
                end
                if (n > 0) pending_results[$].last = 1'b1;
            end
        endcase
    endtask

    // result checking and receiver stalls
    int stall_left;
    always @(posedge aclk) begin
        timer_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result status=%0d msg_id=%h", m_status, m_out_msg_id);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, m_status);
                    errors++;
                end
                if (m_out_msg_id !== exp_r.msg_id) begin
                    $error("out_msg_id expected %h actual %h", exp_r.msg_id, m_out_msg_id);
                    errors++;
                end
                if (m_out_recv_mid !== exp_r.recv_mid) begin
                    $error("out_recv_mid expected %h actual %h", exp_r.recv_mid, m_out_recv_mid);
                    errors++;
                end
                if (m_out_recv_handle !== exp_r.handle) begin
                    $error("out_recv_handle expected %h actual %h", exp_r.handle,
                           m_out_recv_handle);
                    errors++;
                end
                if (m_out_response_type !== exp_r.resp_type) begin
                    $error("out_response_type expected %h actual %h", exp_r.resp_type,
                           m_out_response_type);
                    errors++;
                end
                if (m_last !== exp_r.last) begin
                    $error("last expected %0d actual %0d", exp_r.last, m_last);
                    errors++;
                end
            end
        end
        // random stall bursts, none near the end
        if (calm) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIM) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // drive one request, wait for acceptance and predict its results
    task automatic send_request(timer_req_t q);
        s_valid         <= 1'b1;
        s_cmd           <= q.cmd;
        s_msg_id        <= q.msg_id;
        s_delay_ticks   <= q.delay;
        s_recv_mid      <= q.recv_mid;
        s_recv_handle   <= q.handle;
        s_response_type <= q.resp_type;
        do @(posedge aclk); while (!s_ready);
        predict_request(q);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    function automatic timer_req_t rand_req(cmd_t c, logic [31:0] key, logic [30:0] dly);
        timer_req_t q;
        q.cmd       = c;
        q.msg_id    = key;
        q.delay     = dly;
        q.recv_mid  = $urandom;
        q.handle    = 16'($urandom);
        q.resp_type = $urandom;
        return q;
    endfunction

    // pick a key, mostly from a small pool so hits are common
    function automatic logic [31:0] pick_key();
        logic [31:0] k;
        if (used_keys.size() > 0 && $urandom_range(0, 3) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        k = $urandom;
        if (used_keys.size() < 24) used_keys.push_back(k);
        return k;
    endfunction

    function automatic dir_row_t row(timer_req_t q, bit typed, status_t st,
                                     logic [31:0] mid, logic [15:0] h, logic [31:0] rt,
                                     bit lst);
        dir_row_t r;
        r.req          = q;
        r.typed        = typed;
        r.res          = '0;
        r.res.status   = st;
        r.res.msg_id   = q.msg_id;
        r.res.recv_mid = mid;
        r.res.handle   = h;
        r.res.resp_type = rt;
        r.res.last     = lst;
        return r;
    endfunction

    dir_row_t dir_table [$];

    // stimulus
    initial begin
        timer_req_t q;
        timer_req_t fill;
        int n_sent;
        int sel;
        calm      = 1'b0;
        pr_now    = '0;
        pr_seq    = '0;
        for (int i = 0; i < DEPTH; i++) pr_valid[i] = 1'b0;
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_cmd           <= CMD_TICK;
        s_msg_id        <= '0;
        s_delay_ticks   <= '0;
        s_recv_mid      <= '0;
        s_recv_handle   <= '0;
        s_response_type <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table: extremes, every command, each special case
        dir_table.push_back(row('{CMD_GET, 32'h0, 31'h0, 32'h0, 16'h0, 32'h0},
                                1'b1, ST_NOT_FOUND, '0, '0, '0, 1'b1));
        dir_table.push_back(row('{CMD_CANCEL, 32'hFFFF_FFFF, 31'h7FFF_FFFF, '1, '1, '1},
                                1'b1, ST_CANCELLED, '0, '0, '0, 1'b1));
        dir_table.push_back(row('{CMD_ADD, 32'hFFFF_FFFF, 31'h0, '1, '1, '1},
                                1'b1, ST_ADDED, '0, '0, '0, 1'b1));
        dir_table.push_back(row('{CMD_ADD, 32'hFFFF_FFFF, 31'h5, 32'h1, 16'h1, 32'h1},
                                1'b1, ST_DUPLICATE, '0, '0, '0, 1'b1));
        dir_table.push_back(row('{CMD_ADD, 32'h0, 31'h0, 32'h0, 16'h0, 32'h0},
                                1'b1, ST_ADDED, '0, '0, '0, 1'b1));
        dir_table.push_back(row('{CMD_ADD, 32'h1, 31'h7FFF_FFFF, 32'hA5A5_5A5A, 16'h5AA5,
                                  32'h1234_5678}, 1'b1, ST_ADDED, '0, '0, '0, 1'b1));
        // zero-delay entries expire on the next tick, insertion order on tie
        dir_table.push_back(row('{CMD_TICK, 32'h0, 31'h0, 32'h0, 16'h0, 32'h0},
                                1'b1, ST_EXPIRED, '0, '0, '0, 1'b1));
        dir_table.push_back(row('{CMD_TICK, 32'h0, 31'h0, 32'h0, 16'h0, 32'h0},
                                1'b0, ST_EXPIRED, '0, '0, '0, 1'b0));
        dir_table.push_back(row('{CMD_GET, 32'h1, 31'h0, 32'h0, 16'h0, 32'h0},
                                1'b1, ST_FOUND, 32'hA5A5_5A5A, 16'h5AA5, 32'h1234_5678,
                                1'b1));
        dir_table.push_back(row('{CMD_GET, 32'h1, 31'h0, 32'h0, 16'h0, 32'h0},
                                1'b1, ST_NOT_FOUND, '0, '0, '0, 1'b1));
        dir_table.push_back(row('{CMD_TICK, 32'h0, 31'h0, 32'h0, 16'h0, 32'h0},
                                1'b0, ST_EXPIRED, '0, '0, '0, 1'b0));

        for (int r = 0; r < dir_table.size(); r++) begin
            if (dir_table[r].typed) begin
                send_request(dir_table[r].req);
                if (pending_results.size() == 0 || pending_results[$] !== dir_table[r].res) begin
                    $error("row %0d: status expected %0d actual %0d", r,
                           dir_table[r].res.status,
                           pending_results.size() ? pending_results[$].status : 3'bx);
                    errors++;
                end
            end else begin
                send_request(dir_table[r].req);
            end
        end

        // fill the table, overflow it, then expire all sixteen on one tick
        for (int i = 0; i < DEPTH + 1; i++) begin
            fill = rand_req(CMD_ADD, 32'h100 + i, 31'h1);
            send_request(fill);
        end
        send_request(rand_req(CMD_ADD, 32'h200, 31'h3));
        send_request(rand_req(CMD_TICK, 32'h0, 31'h0));
        send_request(rand_req(CMD_TICK, 32'h0, 31'h0));

        // random part: adds, mostly with short delays, plus ticks, cancels and gets
        n_sent = 0;
        while (n_sent < N_RANDOM) begin
            if (n_sent > N_RANDOM - 60) calm = 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                q = rand_req(CMD_ADD, pick_key(),
                             ($urandom_range(0, 15) == 0) ? 31'($urandom)
                                                          : 31'($urandom_range(0, 12)));
            end else if (sel < 52) begin
                q = rand_req(CMD_CANCEL, pick_key(), 31'($urandom));
            end else if (sel < 64) begin
                q = rand_req(CMD_GET, pick_key(), 31'($urandom));
            end else begin
                q = rand_req(CMD_TICK, $urandom, 31'($urandom));
            end
            send_request(q);
            n_sent++;
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/cdtq_pkg.sv
rtl/core/cdtq_ram.sv
rtl/core/cancellable_deadline_timer_queue_core.sv
tb/testbench.sv
